// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the block bitmap allocator
// Field widths, mode and status codes, config register indexes, the command
// that travels from the front end to the back end, and the state codes.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Field widths
  localparam int BLK_W   = 10;   // block numbers
  localparam int COUNT_W = 11;   // counts and map indexes
  localparam int MAP_MAX = 1024; // highest map index a mark can reach, plus one
  localparam int WORD_MAX = 32;  // bitmap word width
  localparam int Q_DEPTH = 2;    // command queue entries

  localparam logic [COUNT_W-1:0] CNT_RESET = 11'd1024;

  // Request modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_FIND      = 2'd0;
  localparam mode_t MODE_MARK_USED = 2'd1;
  localparam mode_t MODE_MARK_FREE = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_RANGE     = 2'd1;
  localparam status_t STAT_NONE_FREE = 2'd2;

  // Config register indexes
  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_FIRST_DATA_BLOCK = 1'b0;
  localparam cfg_idx_t CFG_DATA_BLOCK_COUNT = 1'b1;

  // Back-end operations
  typedef enum logic [1:0] {
    OP_FIND,
    OP_SET,
    OP_CLEAR,
    OP_REPORT
  } op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DONE
  } bk_state_e;

  // Classified request
  typedef struct packed {
    op_e                 op;
    status_t             status;  // final status for OP_REPORT / marks
    logic [BLK_W-1:0]    idx;     // map index for marks
    logic [COUNT_W-1:0]  lim;     // usable range at accept time
    logic [BLK_W-1:0]    first;   // first data block at accept time
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ===== src/bba_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_in_if: request channel
// Valid/ready channel carrying one allocator request per transfer.
// ----------------------------------------------------------------------------
interface bba_in_if;
  logic                        valid;
  logic                        ready;
  bba_pkg::mode_t              mode;
  logic [bba_pkg::BLK_W-1:0]   block_number;

  modport source (output valid, mode, block_number, input ready);
  modport sink   (input valid, mode, block_number, output ready);
endinterface

// ===== src/bba_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_out_if: result channel
// Valid/ready channel carrying one allocator result per transfer.
// ----------------------------------------------------------------------------
interface bba_out_if;
  logic                          valid;
  logic                          ready;
  bba_pkg::status_t              status;
  logic [bba_pkg::BLK_W-1:0]     found_block;
  logic [bba_pkg::COUNT_W-1:0]   free_count;

  modport source (output valid, status, found_block, free_count, input ready);
  modport sink   (input valid, status, found_block, free_count, output ready);
endinterface

// ===== src/bba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== src/bba_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_front: config registers and request classification
// Holds the range registers, computes the usable range, range-checks marks
// and pushes a classified command into the queue.
// ----------------------------------------------------------------------------
module bba_front #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bba_in_if.sink                        in_ch,
  input  logic                          cfg_we,
  input  bba_pkg::cfg_idx_t             cfg_index,
  input  logic [bba_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                          q_full,
  output bba_pkg::q_push_t              push
);

  localparam int TB_W  = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (TB_W > bba_pkg::COUNT_W) ? TB_W : bba_pkg::COUNT_W;
  localparam logic [CMP_W-1:0] TOTAL_C = CMP_W'(NUM_BLOCKS);

  logic [bba_pkg::BLK_W-1:0]   first_r;
  logic [bba_pkg::COUNT_W-1:0] count_r;

  logic [CMP_W-1:0]            first_ext;
  logic [CMP_W-1:0]            count_ext;
  logic [CMP_W-1:0]            blk_ext;
  logic [CMP_W-1:0]            room;
  logic [bba_pkg::COUNT_W-1:0] lim;
  logic [bba_pkg::BLK_W-1:0]   idx;
  logic                        in_range;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      count_r <= bba_pkg::CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bba_pkg::CFG_FIRST_DATA_BLOCK: first_r <= cfg_data[bba_pkg::BLK_W-1:0];
        bba_pkg::CFG_DATA_BLOCK_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Usable range: min(count, TOTAL - first), zero past the end
  always_comb begin
    first_ext = CMP_W'(first_r);
    count_ext = CMP_W'(count_r);
    room      = TOTAL_C - first_ext;
    if (first_ext >= TOTAL_C) begin
      lim = '0;
    end else if (count_ext < room) begin
      lim = count_r;
    end else begin
      lim = bba_pkg::COUNT_W'(room);
    end
  end

  // Range check for mark requests
  always_comb begin
    blk_ext  = CMP_W'(in_ch.block_number);
    idx      = in_ch.block_number - first_r;
    in_range = (in_ch.block_number >= first_r) && (blk_ext < TOTAL_C) &&
               (bba_pkg::COUNT_W'(idx) < lim);
  end

  // Classify and push
  always_comb begin
    push.valid     = in_ch.valid && !q_full;
    push.cmd.idx   = idx;
    push.cmd.lim   = lim;
    push.cmd.first = first_r;
    case (in_ch.mode)
      bba_pkg::MODE_FIND: begin
        push.cmd.op     = bba_pkg::OP_FIND;
        push.cmd.status = bba_pkg::STAT_OK;
      end
      bba_pkg::MODE_MARK_USED: begin
        push.cmd.op     = in_range ? bba_pkg::OP_SET : bba_pkg::OP_REPORT;
        push.cmd.status = in_range ? bba_pkg::STAT_OK : bba_pkg::STAT_RANGE;
      end
      bba_pkg::MODE_MARK_FREE: begin
        push.cmd.op     = in_range ? bba_pkg::OP_CLEAR : bba_pkg::OP_REPORT;
        push.cmd.status = in_range ? bba_pkg::STAT_OK : bba_pkg::STAT_RANGE;
      end
      default: begin
        // unused mode: plain status report
        push.cmd.op     = bba_pkg::OP_REPORT;
        push.cmd.status = bba_pkg::STAT_OK;
      end
    endcase
  end

  assign in_ch.ready = !q_full;

endmodule

// ===== src/bba_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_queue: command queue between front and back end
// Small FIFO of classified commands so either side can stall on its own.
// ----------------------------------------------------------------------------
module bba_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  bba_pkg::q_push_t  push,
  output logic              full,
  input  logic              pop,
  output bba_pkg::q_head_t  head
);

  localparam int PW = (bba_pkg::Q_DEPTH > 1) ? $clog2(bba_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(bba_pkg::Q_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(bba_pkg::Q_DEPTH - 1);

  bba_pkg::cmd_t  mem_r [bba_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push;

  assign full       = (cnt_r == CW'(bba_pkg::Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

// ===== src/bba_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_back: bitmap store and command execution
// Keeps the used map in a word RAM with a per-word full summary and valid
// bits, runs find and mark commands, tracks the used count and holds the
// result register.
// ----------------------------------------------------------------------------
module bba_back #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bba_pkg::q_head_t  head,
  output logic              pop,
  bba_out_if.source         out_ch
);

  localparam int MAP_BITS = (NUM_BLOCKS < bba_pkg::MAP_MAX) ? NUM_BLOCKS
                                                             : bba_pkg::MAP_MAX;
  localparam int WORD_W   = (MAP_BITS < bba_pkg::WORD_MAX) ? MAP_BITS
                                                           : bba_pkg::WORD_MAX;
  localparam int NWORDS   = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int WA_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int CW       = bba_pkg::COUNT_W;
  localparam int BW       = bba_pkg::BLK_W;

  bba_pkg::bk_state_e state_r, state_nxt;
  bba_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [WA_W-1:0]    word_r, word_nxt;
  logic               none_r, none_nxt;
  logic [CW-1:0]      index_r, index_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [NWORDS-1:0]  full_r, full_nxt;
  logic [NWORDS-1:0]  wvalid_r, wvalid_nxt;

  logic               out_valid_r, out_valid_nxt;
  bba_pkg::status_t   status_r, status_nxt;
  logic [BW-1:0]      found_r, found_nxt;
  logic [CW-1:0]      free_r, free_nxt;

  // RAM ports
  logic               ram_re;
  logic [WA_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic               ram_we;
  logic [WORD_W-1:0]  new_word;

  // Search helpers
  logic [WA_W-1:0]    nf_word;
  logic               nf_any;
  logic [WA_W-1:0]    head_word;
  logic [WORD_W-1:0]  rd_word;
  logic [BIT_W-1:0]   bit_sel;
  logic               cur_bit;
  logic [BIT_W-1:0]   zpos;
  logic               zany;
  logic               find_ok;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_r),
    .wdata (new_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // First word that is not full (summary priority encode)
  always_comb begin
    nf_word = '0;
    nf_any  = 1'b0;
    for (int w = NWORDS - 1; w >= 0; w--) begin
      if (!full_r[w]) begin
        nf_word = WA_W'(w);
        nf_any  = 1'b1;
      end
    end
  end

  assign head_word = WA_W'(head.cmd.idx >> BIT_W);

  // Never-written words read as all free
  assign rd_word = wvalid_r[word_r] ? ram_rdata : '0;
  assign bit_sel = cmd_r.idx[BIT_W-1:0];
  assign cur_bit = rd_word[bit_sel];

  // First clear bit inside the fetched word
  always_comb begin
    zpos = '0;
    zany = 1'b0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!rd_word[b]) begin
        zpos = BIT_W'(b);
        zany = 1'b1;
      end
    end
  end

  assign find_ok = (index_r < cmd_r.lim);

  // Sequencer: pop + read, execute, load result; reports skip the execute step
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    word_nxt      = word_r;
    none_nxt      = none_r;
    index_nxt     = index_r;
    used_nxt      = used_r;
    full_nxt      = full_r;
    wvalid_nxt    = wvalid_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = head_word;
    ram_we        = 1'b0;
    new_word      = rd_word;

    // result register drains on transfer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bba_pkg::BK_IDLE: begin
        if (head.valid && (!out_valid_r || out_ch.ready)) begin
          pop     = 1'b1;
          cmd_nxt = head.cmd;
          if (head.cmd.op == bba_pkg::OP_FIND) begin
            ram_raddr = nf_word;
            word_nxt  = nf_word;
            none_nxt  = !nf_any;
          end else begin
            word_nxt  = head_word;
            none_nxt  = 1'b0;
          end
          ram_re    = (head.cmd.op != bba_pkg::OP_REPORT);
          state_nxt = (head.cmd.op == bba_pkg::OP_REPORT) ? bba_pkg::BK_DONE
                                                          : bba_pkg::BK_EXEC;
        end
      end

      bba_pkg::BK_EXEC: begin
        case (cmd_r.op)
          bba_pkg::OP_FIND: begin
            // all words full: the first free index lies past the stored map
            index_nxt = (!none_r && zany) ? CW'({word_r, zpos}) : CW'(MAP_BITS);
          end
          bba_pkg::OP_SET: begin
            if (!cur_bit) begin
              new_word[bit_sel]  = 1'b1;
              ram_we             = 1'b1;
              wvalid_nxt[word_r] = 1'b1;
              full_nxt[word_r]   = &new_word;
              used_nxt           = used_r + 1'b1;
            end
          end
          bba_pkg::OP_CLEAR: begin
            if (cur_bit) begin
              new_word[bit_sel]  = 1'b0;
              ram_we             = 1'b1;
              wvalid_nxt[word_r] = 1'b1;
              full_nxt[word_r]   = 1'b0;
              used_nxt           = used_r - 1'b1;
            end
          end
          default: ;
        endcase
        state_nxt = bba_pkg::BK_DONE;
      end

      bba_pkg::BK_DONE: begin
        out_valid_nxt = 1'b1;
        if (cmd_r.op == bba_pkg::OP_FIND) begin
          status_nxt = find_ok ? bba_pkg::STAT_OK : bba_pkg::STAT_NONE_FREE;
          found_nxt  = find_ok ? (cmd_r.first + index_r[BW-1:0]) : '0;
        end else begin
          status_nxt = cmd_r.status;
          found_nxt  = '0;
        end
        // free count saturates when the range shrank under the used count
        free_nxt  = (cmd_r.lim > used_r) ? (cmd_r.lim - used_r) : '0;
        state_nxt = bba_pkg::BK_IDLE;
      end

      default: begin
        state_nxt = bba_pkg::BK_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      full_r      <= '0;
      wvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      full_r      <= full_nxt;
      wvalid_r    <= wvalid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    word_r   <= word_nxt;
    none_r   <= none_nxt;
    index_r  <= index_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    free_r   <= free_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.found_block = found_r;
  assign out_ch.free_count  = free_r;

endmodule

// ===== src/block_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator: first-free bitmap allocator over data blocks
// Front end classifies requests, a two-entry queue decouples it from the
// back end that owns the bitmap RAM and the used count.
// ----------------------------------------------------------------------------
// Each request (find lowest free, mark used, mark free) returns one result
// with a status, the found block and the free count. The back end takes a
// find or a mark through three steps (pop with the bitmap word read, execute
// with write-back, result load) and a status-only request (out-of-range mark
// or unused mode) through two (pop, result load). It finishes one request
// before it pops the next, and pops only when the result register is free or
// draining. The find path picks the first non-full word from a per-word
// summary register and then the first clear bit of that word; the single
// bitmap RAM port sets the pace. The map comes out of reset all free through
// per-word valid bits, with no clearing pass, so requests are taken right
// after reset. Config registers are to be written only while no request is
// in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module block_bitmap_allocator #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bba_in_if.sink                        in_ch,
  bba_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  bba_pkg::cfg_idx_t             cfg_index,
  input  logic [bba_pkg::COUNT_W-1:0]   cfg_data
);

  bba_pkg::q_push_t q_push;
  bba_pkg::q_head_t q_head;
  logic             q_full;
  logic             q_pop;

  bba_front #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (q_push)
  );

  bba_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head)
  );

  bba_back #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== test/tb_block_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_bitmap_allocator: self-checking bench for the bitmap allocator
// Directed requests cover the range edges, redundant marks, the unused mode,
// a full map and a range shrunk under marked blocks. Random phases follow,
// each under a fresh range setting, with random idle on both channels in all
// but one. Results are checked field by field against an in-bench bitmap model.
// ----------------------------------------------------------------------------
module tb_block_bitmap_allocator;

  localparam bba_pkg::mode_t MODE_UNUSED = 2'd3;  // ignored by the block
  localparam int             STALL_LIMIT = 4000;  // cycles with no transfer at all
  localparam int             TAIL_CYCLES = 16;    // quiet time after the last result

  typedef struct packed {
    bba_pkg::status_t                status;
    logic [bba_pkg::BLK_W-1:0]       found;
    logic [bba_pkg::COUNT_W-1:0]     free_cnt;
  } alloc_result_t;

  // Bitmap model plus the queue of results still owed by the block
  class bitmap_scoreboard;
    bit [bba_pkg::MAP_MAX-1:0] used_map;
    int unsigned               used_count;
    int unsigned               first_block;
    int unsigned               block_count;
    alloc_result_t             owed_results[$];
    int                        errors;

    function new();
      used_map    = '0;
      used_count  = 0;
      first_block = 0;
      block_count = bba_pkg::CNT_RESET;
      errors      = 0;
    endfunction

    function int unsigned usable_range();
      int unsigned room;
      if (first_block >= bba_pkg::MAP_MAX) return 0;
      room = bba_pkg::MAP_MAX - first_block;
      return (block_count < room) ? block_count : room;
    endfunction

    function int pending_count();
      return owed_results.size();
    endfunction

    function void write_register(bba_pkg::cfg_idx_t idx,
                                 logic [bba_pkg::COUNT_W-1:0] value);
      if (idx == bba_pkg::CFG_FIRST_DATA_BLOCK) first_block = value[bba_pkg::BLK_W-1:0];
      else block_count = value;
    endfunction

    // Work out the result of an accepted request and update the map
    function void note_request(bba_pkg::mode_t req_mode,
                               logic [bba_pkg::BLK_W-1:0] blk);
      alloc_result_t r;
      int unsigned   lim;
      int unsigned   off;
      lim      = usable_range();
      r.status = bba_pkg::STAT_OK;
      r.found  = '0;
      if (req_mode == bba_pkg::MODE_FIND) begin
        r.status = bba_pkg::STAT_NONE_FREE;
        for (int unsigned i = 0; i < lim; i++) begin
          if (!used_map[i]) begin
            r.status = bba_pkg::STAT_OK;
            r.found  = bba_pkg::BLK_W'(first_block + i);
            break;
          end
        end
      end else if (req_mode == bba_pkg::MODE_MARK_USED ||
                   req_mode == bba_pkg::MODE_MARK_FREE) begin
        if (blk < first_block || int'(blk) - first_block >= lim) begin
          r.status = bba_pkg::STAT_RANGE;
        end else begin
          off = blk - first_block;
          if (req_mode == bba_pkg::MODE_MARK_USED && !used_map[off]) begin
            used_map[off] = 1'b1;
            used_count++;
          end else if (req_mode == bba_pkg::MODE_MARK_FREE && used_map[off]) begin
            used_map[off] = 1'b0;
            used_count--;
          end
        end
      end
      // free count saturates once the range shrinks below the used count
      r.free_cnt = (used_count >= lim) ? '0 : bba_pkg::COUNT_W'(lim - used_count);
      owed_results.insert(owed_results.size(), r);
    endfunction

    task log_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(bba_pkg::status_t st, logic [bba_pkg::BLK_W-1:0] found,
                      logic [bba_pkg::COUNT_W-1:0] free_cnt);
      alloc_result_t want;
      if (owed_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result status %0d found %0d free %0d",
                               st, found, free_cnt));
        return;
      end
      want = owed_results.pop_front();
      if (st !== want.status)
        log_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (found !== want.found)
        log_mismatch($sformatf("found_block %0d, want %0d", found, want.found));
      if (free_cnt !== want.free_cnt)
        log_mismatch($sformatf("free_count %0d, want %0d", free_cnt, want.free_cnt));
    endtask
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  bba_pkg::cfg_idx_t           cfg_index;
  logic [bba_pkg::COUNT_W-1:0] cfg_data;
  bit                          steady;       // no idling on either side
  int                          idle_cycles;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  bitmap_scoreboard sb;

  block_bitmap_allocator #(.NUM_BLOCKS(bba_pkg::MAP_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Present one request and hold it until the transfer; valid stays high
  task automatic send_request(input bba_pkg::mode_t m,
                              input logic [bba_pkg::BLK_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.block_number <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait for every owed result
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // Write both range registers; only called with the block idle
  task automatic set_range(input int unsigned first_blk, input int unsigned blk_count);
    cfg_we    <= 1'b1;
    cfg_index <= bba_pkg::CFG_FIRST_DATA_BLOCK;
    cfg_data  <= bba_pkg::COUNT_W'(first_blk);
    @(posedge clk);
    cfg_index <= bba_pkg::CFG_DATA_BLOCK_COUNT;
    cfg_data  <= bba_pkg::COUNT_W'(blk_count);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_register(bba_pkg::CFG_FIRST_DATA_BLOCK, bba_pkg::COUNT_W'(first_blk));
    sb.write_register(bba_pkg::CFG_DATA_BLOCK_COUNT, bba_pkg::COUNT_W'(blk_count));
  endtask

  // Mostly marks inside the range and finds, some out-of-range and unused mode
  task automatic random_request();
    int                        r;
    int unsigned               lim;
    bba_pkg::mode_t            m;
    logic [bba_pkg::BLK_W-1:0] b;
    lim = sb.usable_range();
    r   = $urandom_range(0, 99);
    b   = bba_pkg::BLK_W'($urandom_range(0, bba_pkg::MAP_MAX - 1));
    if (r < 30) begin
      m = bba_pkg::MODE_FIND;
    end else if (r < 85) begin
      m = (r < 60) ? bba_pkg::MODE_MARK_USED : bba_pkg::MODE_MARK_FREE;
      if (lim != 0) b = bba_pkg::BLK_W'(sb.first_block + $urandom_range(0, lim - 1));
    end else if (r < 95) begin
      m = ($urandom_range(0, 1) != 0) ? bba_pkg::MODE_MARK_USED
                                      : bba_pkg::MODE_MARK_FREE;
    end else begin
      m = MODE_UNUSED;
    end
    send_request(m, b);
  endtask

  // Result side ready pattern
  initial begin : result_sink
    int hold;
    int stall;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold != 0) begin
        hold--;
      end else if (steady || !out_ch.ready) begin
        out_ch.ready <= 1'b1;
        hold = steady ? 0 : $urandom_range(0, 15);
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          hold = stall - 1;
        end else begin
          hold = $urandom_range(0, 15);
        end
      end
    end
  end

  // Transfer monitor: check results, log requests, track quiet cycles
  always @(posedge clk) begin
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.status, out_ch.found_block, out_ch.free_count);
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(in_ch.mode, in_ch.block_number);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end else begin
      idle_cycles = 0;
    end
  end

  // Watchdog
  initial begin : watchdog
    @(posedge clk);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("block_bitmap_allocator regression: fail");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int n_items;
    sb                 = new();
    steady             = 1'b0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= bba_pkg::CFG_FIRST_DATA_BLOCK;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= bba_pkg::MODE_FIND;
    in_ch.block_number <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // default range, whole map
    send_request(bba_pkg::MODE_FIND,      10'd0);
    send_request(bba_pkg::MODE_MARK_USED, 10'd0);
    send_request(bba_pkg::MODE_FIND,      10'd1023);
    send_request(bba_pkg::MODE_MARK_USED, 10'd1023);
    send_request(bba_pkg::MODE_MARK_FREE, 10'd1023);
    send_request(bba_pkg::MODE_MARK_USED, 10'd5);
    send_request(bba_pkg::MODE_MARK_USED, 10'd5);    // already used
    send_request(bba_pkg::MODE_MARK_FREE, 10'd6);    // already free
    send_request(MODE_UNUSED,             10'd1023);
    send_request(bba_pkg::MODE_MARK_USED, 10'd682);
    send_request(bba_pkg::MODE_MARK_USED, 10'd341);

    // one-block range at the top of the map, offset 0 already used
    wait_idle();
    set_range(1023, 1024);
    send_request(bba_pkg::MODE_FIND,      10'd0);    // nothing free
    send_request(bba_pkg::MODE_MARK_USED, 10'd1022); // below the range
    send_request(bba_pkg::MODE_MARK_FREE, 10'd1023);
    send_request(bba_pkg::MODE_FIND,      10'd0);
    send_request(bba_pkg::MODE_MARK_USED, 10'd1023);

    // empty range
    wait_idle();
    set_range(0, 0);
    send_request(bba_pkg::MODE_FIND,      10'd0);
    send_request(bba_pkg::MODE_MARK_USED, 10'd0);
    send_request(MODE_UNUSED,             10'd0);

    // mark a few, then shrink the range below the used count
    wait_idle();
    set_range(0, 1024);
    send_request(bba_pkg::MODE_MARK_USED, 10'd1);
    send_request(bba_pkg::MODE_MARK_USED, 10'd2);
    wait_idle();
    set_range(0, 2);
    send_request(bba_pkg::MODE_FIND,      10'd0);
    send_request(bba_pkg::MODE_MARK_FREE, 10'd1);
    send_request(bba_pkg::MODE_MARK_USED, 10'd2);    // beyond the shrunk range
    send_request(bba_pkg::MODE_FIND,      10'd0);

    // random phases, one range setting each
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      steady = 1'b0;
      case (ph)
        0: set_range(0, 1024);
        1: set_range($urandom_range(0, 1023), $urandom_range(1, 12));
        2: set_range(1023, 1024);
        3: set_range($urandom_range(900, 1020), 1024);
        4: set_range($urandom_range(0, 1023), $urandom_range(0, 64));
        5: set_range(0, 0);
        6: set_range($urandom_range(0, 20), $urandom_range(1, 8));
        default: set_range($urandom_range(0, 1023), $urandom_range(0, 1024));
      endcase
      steady  = (ph == 6);
      n_items = (ph == 5) ? 30 : 100;
      repeat (n_items) begin
        if ($urandom_range(0, 59) == 0) wait_idle();
        random_request();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("block_bitmap_allocator regression: pass");
    else
      $display("block_bitmap_allocator regression: fail");
    $finish;
  end

endmodule
